// ----- hdl/bmtr_pkg.sv -----
package bmtr_pkg;

	localparam int CoordW    = 10;
	localparam int CursorW   = 11;
	localparam int ColorW    = 16;
	localparam int CodeW     = 8;
	localparam int GlyphCols = 5;
	localparam int GlyphRows = 8;
	localparam int GlyphBits = GlyphCols * GlyphRows;
	localparam int GlyphCount = 96;
	localparam int InDataW   = 48;
	localparam int OutDataW  = 40;

	localparam logic [CodeW-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CodeW-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CodeW-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CodeW-1:0] CHAR_FIRST = 8'h20;
	localparam logic [CodeW-1:0] CHAR_TOP   = 8'h7F;

	localparam logic [CursorW-1:0] ADVANCE_X = 11'd6;
	localparam logic [CursorW-1:0] LINE_STEP = 11'd8;

	localparam logic [CoordW-1:0] WIDTH_RESET  = 10'd240;
	localparam logic [CoordW-1:0] HEIGHT_RESET = 10'd320;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic draw;
		logic rem_empty;
		logic out_free;
	} status_t;

	// One entry per glyph; bit col*8+row, bit 0 of each column is the top row.
	localparam logic [GlyphBits-1:0] GLYPH_ROM [GlyphCount] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h12_2A_7F_2A_24, 40'h62_64_08_13_23, 40'h50_22_55_49_36, 40'h00_00_03_05_00,
		40'h00_41_22_1C_00, 40'h00_1C_22_41_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_00_30_50_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00, 40'h02_04_08_10_20,
		40'h3E_45_49_51_3E, 40'h00_40_7F_42_00, 40'h46_49_49_49_72, 40'h31_4B_4D_49_21,
		40'h10_7F_12_14_18, 40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
		40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00, 40'h00_00_36_56_00,
		40'h00_41_22_14_08, 40'h14_14_14_14_14, 40'h08_14_22_41_00, 40'h06_09_59_01_02,
		40'h4E_59_5D_41_3E, 40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
		40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_09_09_09_7F, 40'h7A_49_49_41_3E,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h01_3F_41_40_20, 40'h41_22_14_08_7F,
		40'h40_40_40_40_7F, 40'h7F_02_0C_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E,
		40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F, 40'h31_49_49_49_46,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
		40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h43_45_49_51_61, 40'h00_41_41_7F_00,
		40'h20_10_08_04_02, 40'h00_7F_41_41_00, 40'h04_02_01_02_04, 40'h80_80_80_80_80,
		40'h00_00_05_03_00, 40'h78_54_54_54_20, 40'h38_44_44_48_7F, 40'h20_44_44_44_38,
		40'h7F_48_44_44_38, 40'h18_54_54_54_38, 40'h02_01_09_7E_08, 40'h3E_52_52_52_0C,
		40'h78_04_04_08_7F, 40'h00_40_7D_44_00, 40'h00_3D_44_40_20, 40'h00_44_28_10_7F,
		40'h00_40_7F_41_00, 40'h78_04_18_04_7C, 40'h78_04_04_08_7C, 40'h38_44_44_44_38,
		40'h08_14_14_14_7C, 40'h7C_18_14_14_08, 40'h08_04_04_08_7C, 40'h20_54_54_54_48,
		40'h20_40_44_3F_04, 40'h7C_20_40_40_3C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
		40'h44_28_10_28_44, 40'h3C_50_50_50_0C, 40'h44_4C_54_64_44, 40'h00_41_36_08_00,
		40'h00_00_7F_00_00, 40'h00_08_36_41_00, 40'h08_1C_2A_08_08, 40'h00_00_00_00_00
	};

	// Codes outside the font draw as space.
	function automatic logic [GlyphBits-1:0] glyph_bits(input logic [CodeW-1:0] code);
		logic [CodeW-1:0] idx;
		idx = '0;
		if (code >= CHAR_FIRST && code <= CHAR_TOP) begin
			idx = code - CHAR_FIRST;
		end
		return GLYPH_ROM[idx[6:0]];
	endfunction

endpackage

// ----- hdl/bmtr_ctrl.sv -----
module bmtr_ctrl
	import bmtr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.draw) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.rem_empty) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SCAN: begin
				cmd.step = !status.rem_empty && status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- hdl/bmtr_datapath.sv -----
module bmtr_datapath
	import bmtr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CoordW-1:0] cfg_data,
	input  logic              in_start,
	input  logic [CodeW-1:0]  in_code,
	input  logic [CoordW-1:0] in_origin_x,
	input  logic [CoordW-1:0] in_origin_y,
	input  logic [ColorW-1:0] in_color,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [CoordW-1:0] out_x,
	output logic [CoordW-1:0] out_y,
	output logic [ColorW-1:0] out_color,
	output logic              out_last,
	input  cmd_t              cmd,
	output status_t           status
);

	logic [CoordW-1:0]    screen_width_q;
	logic [CoordW-1:0]    screen_height_q;
	logic [CursorW-1:0]   cursor_x_q;
	logic [CursorW-1:0]   cursor_y_q;
	logic [CursorW-1:0]   line_start_q;
	logic                 stopped_q;

	logic [GlyphBits-1:0] rem_q;
	logic [2:0]           col_q;
	logic [2:0]           row_q;
	logic [CursorW-1:0]   base_x_q;
	logic [CursorW-1:0]   base_y_q;
	logic [ColorW-1:0]    color_q;

	logic                 out_valid_q;
	logic [CoordW-1:0]    out_x_q;
	logic [CoordW-1:0]    out_y_q;
	logic [ColorW-1:0]    out_color_q;
	logic                 out_last_q;

	logic                 eff_stopped;
	logic [CursorW-1:0]   cx;
	logic [CursorW-1:0]   cy;
	logic [CursorW-1:0]   lsx;
	logic [CursorW-1:0]   adv_x;
	logic [CursorW-1:0]   next_x;
	logic [CursorW-1:0]   next_y;
	logic                 is_ctrl;
	logic                 hit_bottom;
	logic [GlyphCols-1:0] col_ok;
	logic [GlyphRows-1:0] row_ok;
	logic [GlyphBits-1:0] glyph;
	logic [GlyphBits-1:0] vis_mask;
	logic [CursorW-1:0]   pix_x;
	logic [CursorW-1:0]   pix_y;

	always_comb begin
		eff_stopped = in_start ? 1'b0 : stopped_q;
		cx  = in_start ? {1'b0, in_origin_x} : cursor_x_q;
		cy  = in_start ? {1'b0, in_origin_y} : cursor_y_q;
		lsx = in_start ? {1'b0, in_origin_x} : line_start_q;
		is_ctrl = (in_code == CHAR_NUL) || (in_code == CHAR_LF) || (in_code == CHAR_CR);
		adv_x = cx + ADVANCE_X;

		next_x = cx;
		next_y = cy;
		case (in_code)
			CHAR_NUL: begin
				next_x = cx;
				next_y = cy;
			end
			CHAR_LF: begin
				next_x = lsx;
				next_y = cy + LINE_STEP;
			end
			CHAR_CR: begin
				next_x = lsx;
				next_y = cy;
			end
			default: begin
				if (({1'b0, adv_x} + 12'd5) >= {2'b00, screen_width_q}) begin
					next_x = lsx;
					next_y = cy + LINE_STEP;
				end else begin
					next_x = adv_x;
					next_y = cy;
				end
			end
		endcase
		hit_bottom = ({1'b0, next_y} + 12'd7) >= {2'b00, screen_height_q};

		// Clip against the screen per column and per row, then mask the glyph.
		for (int c = 0; c < GlyphCols; c++) begin
			col_ok[c] = ({1'b0, cx} + 12'(c)) < {2'b00, screen_width_q};
		end
		for (int r = 0; r < GlyphRows; r++) begin
			row_ok[r] = ({1'b0, cy} + 12'(r)) < {2'b00, screen_height_q};
		end
		glyph = glyph_bits(in_code);
		for (int b = 0; b < GlyphBits; b++) begin
			vis_mask[b] = glyph[b] && col_ok[b / GlyphRows] && row_ok[b % GlyphRows];
		end

		pix_x = base_x_q + {8'd0, col_q};
		pix_y = base_y_q + {8'd0, row_q};
	end

	assign status.draw      = !eff_stopped && !is_ctrl;
	assign status.rem_empty = (rem_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= WIDTH_RESET;
			screen_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  screen_width_q  <= cfg_data;
				REG_HEIGHT: screen_height_q <= cfg_data;
				default:    screen_width_q  <= screen_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
			stopped_q    <= 1'b1;
		end else if (cmd.accept && !eff_stopped) begin
			cursor_x_q   <= next_x;
			cursor_y_q   <= next_y;
			line_start_q <= lsx;
			stopped_q    <= (in_code == CHAR_NUL) || hit_bottom;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept && status.draw) begin
			rem_q <= vis_mask;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.step) begin
			rem_q <= rem_q >> 1;
			row_q <= row_q + 3'd1;
			if (row_q == 3'(GlyphRows - 1)) begin
				col_q <= col_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && status.draw) begin
			base_x_q <= cx;
			base_y_q <= cy;
			color_q  <= in_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step && rem_q[0]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The pixel is final when no visible bit remains above it.
	always_ff @(posedge clk) begin
		if (cmd.step && rem_q[0]) begin
			out_x_q     <= pix_x[CoordW-1:0];
			out_y_q     <= pix_y[CoordW-1:0];
			out_color_q <= color_q;
			out_last_q  <= (rem_q[GlyphBits-1:1] == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_color = out_color_q;
	assign out_last  = out_last_q;

	a_pixel_x_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && rem_q[0]) |-> (pix_x < {1'b0, screen_width_q}))
		else $error("emitted pixel beyond screen width");

	a_pixel_y_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && rem_q[0]) |-> (pix_y < {1'b0, screen_height_q}))
		else $error("emitted pixel beyond screen height");

	a_scan_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> (col_q < 3'(GlyphCols)))
		else $error("scan column ran past the glyph");

	a_step_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && rem_q[0]) |=> (out_valid_q && (out_last_q == ($past(rem_q) <= 40'd1))))
		else $error("pixel transfer lost or last flag wrong");

endmodule

// ----- hdl/bitmap_text_renderer_5x8.sv -----
// 5x8 bitmap text renderer. Each accepted byte on the s_ side is one character; a set
// s_tuser starts a new string at the origin given with it. Control bytes (terminator,
// newline, carriage return) and ignored bytes give no pixels and leave the block idle.
// Any other byte is accepted and then scanned: the block steps through the positions
// of its clipped glyph mask (5 columns by 8 rows, column-major, ending at its last
// visible lit pixel, at most 40) one position per cycle while the output register is
// free, then returns to idle. Each visible lit pixel leaves as one m_ transfer through
// an output register, with m_tlast on the final pixel of the character; a fully clipped
// character gives no transfer. Screen size is written through cfg_we/cfg_index/cfg_data
// (index 0 width, 1 height), by the user only while idle; the block does not enforce it.
module bitmap_text_renderer_5x8
	import bmtr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CoordW-1:0]   cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // char_code[7:0], origin_x[17:8], origin_y[27:18], color[43:28]
	input  logic                s_tuser,   // start_req
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // pixel_x[9:0], pixel_y[19:10], pixel_color[35:20]
	output logic                m_tlast    // last
);

	cmd_t              cmd;
	status_t           status;
	logic [CoordW-1:0] px;
	logic [CoordW-1:0] py;
	logic [ColorW-1:0] pcolor;

	bmtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bmtr_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_start    (s_tuser),
		.in_code     (s_tdata[7:0]),
		.in_origin_x (s_tdata[17:8]),
		.in_origin_y (s_tdata[27:18]),
		.in_color    (s_tdata[43:28]),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_x       (px),
		.out_y       (py),
		.out_color   (pcolor),
		.out_last    (m_tlast),
		.cmd         (cmd),
		.status      (status)
	);

	assign m_tdata = {4'd0, pcolor, py, px};

endmodule

// ----- bench/bitmap_text_renderer_5x8_test.sv -----
module bitmap_text_renderer_5x8_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 64;
	localparam int HOLDOFF_CYCLES = 500;
	localparam int PRINT_CAP = 100;
	localparam int GLYPH_PITCH = 6;
	localparam int ROW_PITCH = 8;

	typedef struct packed {
		logic        start;
		logic [7:0]  code;
		logic [9:0]  ox;
		logic [9:0]  oy;
		logic [15:0] color;
	} char_t;

	typedef struct {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [15:0] color;
		logic        last;
	} pixel_t;

	// Column bytes of each glyph, column 0 in the top byte; bit 0 of a column is the top row.
	localparam logic [39:0] FONT [96] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
		40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
		40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
		40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
		40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h72_49_49_49_46, 40'h21_49_4D_4B_31,
		40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
		40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
		40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_59_09_06,
		40'h3E_41_5D_59_4E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
		40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
		40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
		40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
		40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
		40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
		40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
		40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h80_80_80_80_80,
		40'h00_03_05_00_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
		40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
		40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
		40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
		40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
		40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
		40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
		40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h00_00_00_00_00
	};

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic                          cfg_index = bmtr_pkg::REG_WIDTH;
	logic [bmtr_pkg::CoordW-1:0]   cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [bmtr_pkg::InDataW-1:0]  s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [bmtr_pkg::OutDataW-1:0] m_tdata;
	logic                          m_tlast;

	bitmap_text_renderer_5x8 DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// renderer state as the predictor sees it
	logic [9:0]  scr_w = 10'd240;
	logic [9:0]  scr_h = 10'd320;
	logic [10:0] cur_x = '0;
	logic [10:0] cur_y = '0;
	logic [10:0] line_x = '0;
	logic        halted = 1'b1;

	char_t  char_queue[$];
	pixel_t pixel_due[$];
	int     mismatch_count = 0;
	int     cycle_count = 0;
	logic   took_char = 1'b0;

	int    gap_left = 0;
	int    burst_left = 0;
	char_t next_char;

	int holdoff_asked = 0;
	int holdoff_served = 0;
	int stall_left = 0;
	int mode_left = 0;
	int stall_pct = 0;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP) begin
			$display("MISMATCH @%0t: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	task automatic render_char(input logic start, input logic [7:0] code,
			input logic [9:0] ox, input logic [9:0] oy, input logic [15:0] color);
		logic [39:0] cols;
		logic [7:0]  bits;
		int          px, py, c, r, n;
		pixel_t      p;
		if (start) begin
			cur_x = {1'b0, ox};
			cur_y = {1'b0, oy};
			line_x = {1'b0, ox};
			halted = 1'b0;
		end
		if (halted) return;
		if (code == bmtr_pkg::CHAR_NUL) begin
			halted = 1'b1;
			return;
		end
		if (code == bmtr_pkg::CHAR_LF) begin
			cur_x = line_x;
			cur_y = cur_y + 11'(ROW_PITCH);
		end else if (code == bmtr_pkg::CHAR_CR) begin
			cur_x = line_x;
		end else begin
			cols = FONT[0];
			if (code >= bmtr_pkg::CHAR_FIRST && code <= bmtr_pkg::CHAR_TOP) begin
				cols = FONT[code - bmtr_pkg::CHAR_FIRST];
			end
			n = 0;
			for (c = 0; c < 5; c++) begin
				bits = cols[39 - 8 * c -: 8];
				for (r = 0; r < 8; r++) begin
					px = int'(cur_x) + c;
					py = int'(cur_y) + r;
					if (bits[r] && px < int'(scr_w) && py < int'(scr_h)) begin
						p.x = 10'(px);
						p.y = 10'(py);
						p.color = color;
						p.last = 1'b0;
						pixel_due.push_back(p);
						n++;
					end
				end
			end
			if (n > 0) pixel_due[pixel_due.size() - 1].last = 1'b1;
			cur_x = cur_x + 11'(GLYPH_PITCH);
			if (int'(cur_x) + 5 >= int'(scr_w)) begin
				cur_x = line_x;
				cur_y = cur_y + 11'(ROW_PITCH);
			end
		end
		if (int'(cur_y) + 7 >= int'(scr_h)) halted = 1'b1;
	endtask

	// sender: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || took_char)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (char_queue.size() > 0) begin
				next_char = char_queue.pop_front();
				s_tdata <= {4'b0, next_char.color, next_char.oy, next_char.ox, next_char.code};
				s_tuser <= next_char.start;
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random stall rate that changes at random intervals, plus long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			if (holdoff_served != holdoff_asked) begin
				holdoff_served = holdoff_asked;
				stall_left = HOLDOFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(50, 300);
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 10;
						2: stall_pct = 40;
						default: stall_pct = 75;
					endcase
				end
				mode_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			took_char <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				render_char(s_tuser, s_tdata[7:0], s_tdata[17:8], s_tdata[27:18], s_tdata[43:28]);
			end
			if (m_tvalid && m_tready) begin
				if (pixel_due.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%b",
						m_tdata[9:0], m_tdata[19:10], m_tdata[35:20], m_tlast));
				end else begin
					pixel_t want;
					want = pixel_due.pop_front();
					if (m_tdata[9:0] !== want.x || m_tdata[19:10] !== want.y
							|| m_tdata[35:20] !== want.color || m_tlast !== want.last) begin
						report_mismatch($sformatf(
							"pixel got x=%0d y=%0d color=%h last=%b, want x=%0d y=%0d color=%h last=%b",
							m_tdata[9:0], m_tdata[19:10], m_tdata[35:20], m_tlast,
							want.x, want.y, want.color, want.last));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_char(input logic start, input logic [7:0] code,
			input logic [9:0] ox, input logic [9:0] oy, input logic [15:0] color);
		char_t ch;
		ch.start = start;
		ch.code = code;
		ch.ox = ox;
		ch.oy = oy;
		ch.color = color;
		char_queue.push_back(ch);
	endtask

	// wait until every character is taken and every pixel has arrived, then let the block go idle
	task automatic settle();
		@(negedge clk);
		while (char_queue.size() != 0 || s_tvalid || pixel_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_screen(input logic [9:0] w, input logic [9:0] h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bmtr_pkg::REG_WIDTH;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= bmtr_pkg::REG_HEIGHT;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	// mostly well-formed strings with random content, the rest raw noise
	task automatic add_random(input int count);
		int         left, len, k, r;
		logic [9:0] ox, oy;
		logic [7:0] code;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 6) == 0) begin
					ox = 10'($urandom);
					oy = 10'($urandom);
				end else begin
					ox = 10'($urandom_range(0, scr_w - 1));
					oy = 10'($urandom_range(0, scr_h - 1));
				end
				push_char(1'b1, 8'($urandom_range(bmtr_pkg::CHAR_FIRST, bmtr_pkg::CHAR_TOP)),
					ox, oy, 16'($urandom));
				len = $urandom_range(1, 16);
				// keep the string inside the remaining budget
				if (len >= left) len = (left > 1) ? left - 1 : 1;
				for (k = 0; k < len; k++) begin
					r = $urandom_range(0, 19);
					if (r < 16) code = 8'($urandom_range(8'h21, 8'h7E));
					else if (r == 16) code = bmtr_pkg::CHAR_LF;
					else if (r == 17) code = bmtr_pkg::CHAR_CR;
					else if (r == 18) code = 8'($urandom_range(1, 8'h1F));
					else code = 8'($urandom_range(8'h7F, 8'hFF));
					push_char(1'b0, code, 10'($urandom), 10'($urandom), 16'($urandom));
				end
				left -= len + 1;
				if ($urandom_range(0, 1) == 1) begin
					push_char(1'b0, bmtr_pkg::CHAR_NUL, 10'($urandom), 10'($urandom), 16'($urandom));
					left--;
				end
			end else begin
				push_char($urandom_range(0, 3) == 0, 8'($urandom), 10'($urandom),
					10'($urandom), 16'($urandom));
				left--;
			end
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset screen size, directed characters
		push_char(1'b1, 8'h41, 10'd0, 10'd0, 16'hFFFF);
		push_char(1'b0, 8'h30, 10'd0, 10'd0, 16'h0000);
		push_char(1'b0, 8'h7F, 10'd0, 10'd0, 16'h1234);
		push_char(1'b0, 8'h1F, 10'd0, 10'd0, 16'h1234);
		push_char(1'b0, 8'h80, 10'd0, 10'd0, 16'h1234);
		push_char(1'b0, 8'hFF, 10'd0, 10'd0, 16'h1234);
		push_char(1'b0, bmtr_pkg::CHAR_LF, 10'd0, 10'd0, 16'h0000);
		push_char(1'b0, 8'h5F, 10'd0, 10'd0, 16'hF800);
		push_char(1'b0, bmtr_pkg::CHAR_CR, 10'd0, 10'd0, 16'h0000);
		push_char(1'b0, 8'h7E, 10'd1023, 10'd1023, 16'h07E0);
		push_char(1'b0, 8'h20, 10'd0, 10'd0, 16'hFFFF);
		push_char(1'b0, bmtr_pkg::CHAR_NUL, 10'd0, 10'd0, 16'h0000);
		push_char(1'b0, 8'h42, 10'd0, 10'd0, 16'hFFFF);
		push_char(1'b1, bmtr_pkg::CHAR_NUL, 10'd5, 10'd5, 16'hFFFF);
		push_char(1'b1, 8'h4D, 10'd1023, 10'd1023, 16'hAAAA);
		push_char(1'b0, 8'h51, 10'd0, 10'd0, 16'hFFFF);
		push_char(1'b1, 8'h57, 10'd236, 10'd0, 16'h5555);
		push_char(1'b0, 8'h58, 10'd0, 10'd0, 16'h001F);
		push_char(1'b1, 8'h23, 10'd0, 10'd313, 16'hFFFF);
		push_char(1'b0, 8'h24, 10'd0, 10'd0, 16'hFFFF);
		push_char(1'b1, 8'hFF, 10'd100, 10'd100, 16'hFFFF);
		push_char(1'b1, bmtr_pkg::CHAR_LF, 10'd10, 10'd300, 16'h0000);
		push_char(1'b0, 8'h48, 10'd0, 10'd0, 16'hC618);
		push_char(1'b1, bmtr_pkg::CHAR_CR, 10'd512, 10'd0, 16'h0000);
		push_char(1'b0, 8'h6A, 10'd0, 10'd0, 16'h8410);
		settle();

		set_screen(10'd1023, 10'd1023);
		add_random(60);
		settle();

		set_screen(10'd1, 10'd1);
		add_random(30);
		settle();

		// hold the receiver off while the sender keeps offering characters
		set_screen(10'd100, 10'd60);
		add_random(80);
		holdoff_asked++;
		settle();

		set_screen(10'd1023, 10'd8);
		add_random(30);
		settle();

		set_screen(10'd6, 10'd1023);
		add_random(30);
		settle();

		set_screen(10'($urandom_range(20, 400)), 10'($urandom_range(20, 400)));
		add_random(40);
		settle();
		add_random(40);
		settle();

		set_screen(10'd240, 10'd320);
		add_random(25);
		holdoff_asked++;
		settle();

		if (pixel_due.size() != 0) begin
			report_mismatch($sformatf("%0d pixels never arrived", pixel_due.size()));
		end
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
